@@ src/fcw_pkg.sv @@
`timescale 1ns / 1ps
package fcw_pkg;

  // Table geometry and field widths
  localparam int TableEntriesDefault = 4096;
  localparam int IdxW = 12;
  localparam int EntryW = IdxW + 1;
  localparam int StepW = 13;

  // Item function codes
  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_STEP  = 2'd2;
  localparam logic [1:0] FN_NONE  = 2'd3;

  // Walk position
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NODE,
    PH_RUN
  } phase_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NODE,
    ST_PAIR
  } state_t;

  typedef struct packed {
    logic [1:0]      func;
    logic [IdxW-1:0] entry_index;
    logic [IdxW-1:0] entry_next;
    logic            entry_flag;
    logic [IdxW-1:0] start_index;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0] block_number;
    logic            has_block;
    logic            chain_end;
    logic            bad_index;
  } result_t;

endpackage

@@ src/fcw_ram.sv @@
`timescale 1ns / 1ps
module fcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fat_chain_walker.sv @@
`timescale 1ns / 1ps
// Walks a block allocation table held in one single-port-read RAM and returns,
// one step beat at a time, the data block numbers of a chain. Load and start
// beats, a step inside an extended run and a step that fails on the count or
// index check finish in ST_IDLE. A plain node step passes ST_NODE (one RAM
// read of the node entry); a flagged node step whose following entry is in
// range passes ST_NODE and ST_PAIR, as the run end lives in the next entry and
// needs a second dependent read through the same read port. Only one item is
// in flight; a new beat is taken once the output register is free or being
// drained. The table is not cleared at reset and must be loaded before use.
module fat_chain_walker #(
  parameter int TABLE_ENTRIES = fcw_pkg::TableEntriesDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  fcw_pkg::item_t         item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output fcw_pkg::result_t       result,
  input  logic                   cfg_we,
  input  logic [fcw_pkg::IdxW-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int IW = fcw_pkg::IdxW;
  localparam int SW = fcw_pkg::StepW;

  fcw_pkg::state_t       state, state_next;
  fcw_pkg::phase_t       phase, phase_next;
  logic [IW-1:0]         current_node, current_node_next;
  logic [IW-1:0]         run_position, run_position_next;
  logic [IW-1:0]         run_last, run_last_next;
  logic [IW-1:0]         pair_next, pair_next_next;
  logic [SW-1:0]         step_count, step_count_next;
  logic [IW-1:0]         entry_count;
  fcw_pkg::result_t      result_next;
  logic                  result_valid_next;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [fcw_pkg::EntryW-1:0] ram_rdata;

  logic                  accept;
  logic [IW:0]           node_succ;
  logic [IW-1:0]         node_blk;
  logic                  node_has;
  logic                  emit, e_has, e_end, e_bad;
  logic [IW-1:0]         e_blk;

  // Index check against the active count and the table size
  function automatic logic idx_ok(input logic [IW:0] i, input logic [IW-1:0] cnt);
    return (i < {1'b0, cnt}) && (32'(i) < TABLE_ENTRIES);
  endfunction

  assign item_ready = !rst && (state == fcw_pkg::ST_IDLE) &&
                      (!result_valid || result_ready);
  assign accept     = item_valid && item_ready;
  assign node_succ  = {1'b0, current_node} + (IW+1)'(1);
  assign node_has   = (current_node != '0);
  assign node_blk   = current_node - IW'(1);

  // Table loads go straight in on the accepting edge
  assign ram_we = accept && (item.func == fcw_pkg::FN_LOAD) &&
                  (32'(item.entry_index) < TABLE_ENTRIES);

  fcw_ram #(
    .WIDTH (fcw_pkg::EntryW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(item.entry_index)),
    .wdata ({item.entry_flag, item.entry_next}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '1;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  // State and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fcw_pkg::ST_IDLE;
      phase        <= fcw_pkg::PH_IDLE;
      current_node <= '0;
      run_position <= '0;
      run_last     <= '0;
      step_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      current_node <= current_node_next;
      run_position <= run_position_next;
      run_last     <= run_last_next;
      step_count   <= step_count_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pair_next <= pair_next_next;
    result    <= result_next;
  end

  // Sequencer
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    current_node_next = current_node;
    run_position_next = run_position;
    run_last_next     = run_last;
    pair_next_next    = pair_next;
    step_count_next   = step_count;
    result_next       = result;
    result_valid_next = result_valid && !result_ready;
    ram_raddr         = AW'(current_node);
    emit              = 1'b0;
    e_blk             = '0;
    e_has             = 1'b0;
    e_end             = 1'b0;
    e_bad             = 1'b0;

    case (state)
      fcw_pkg::ST_IDLE: begin
        if (accept) begin
          case (item.func)
            fcw_pkg::FN_START: begin
              current_node_next = item.start_index;
              run_position_next = '0;
              run_last_next     = '0;
              step_count_next   = '0;
              phase_next        = fcw_pkg::PH_NODE;
            end
            fcw_pkg::FN_STEP: begin
              if (phase != fcw_pkg::PH_IDLE) begin
                if (step_count >= {1'b0, entry_count}) begin
                  // walk too long
                  emit  = 1'b1;
                  e_bad = 1'b1;
                end else begin
                  if (step_count != '1) begin
                    step_count_next = step_count + SW'(1);
                  end
                  if (phase == fcw_pkg::PH_NODE) begin
                    if (!idx_ok({1'b0, current_node}, entry_count)) begin
                      emit  = 1'b1;
                      e_bad = 1'b1;
                    end else begin
                      state_next = fcw_pkg::ST_NODE;
                    end
                  end else begin
                    // inside an extended run
                    if (run_position == '0 || !idx_ok({1'b0, run_position}, entry_count)) begin
                      emit  = 1'b1;
                      e_bad = 1'b1;
                    end else begin
                      emit  = 1'b1;
                      e_has = 1'b1;
                      e_blk = run_position - IW'(1);
                      if (run_position >= run_last) begin
                        phase_next = fcw_pkg::PH_NODE;
                        e_end      = (current_node == '0);
                      end else begin
                        run_position_next = run_position + IW'(1);
                      end
                    end
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      fcw_pkg::ST_NODE: begin
        // node entry is on the read port; fetch successor for a flagged node
        ram_raddr = AW'(node_succ);
        if (ram_rdata[IW]) begin
          if (!idx_ok(node_succ, entry_count)) begin
            emit       = 1'b1;
            e_has      = node_has;
            e_blk      = node_has ? node_blk : '0;
            e_bad      = 1'b1;
            state_next = fcw_pkg::ST_IDLE;
          end else begin
            pair_next_next = ram_rdata[IW-1:0];
            state_next     = fcw_pkg::ST_PAIR;
          end
        end else begin
          current_node_next = ram_rdata[IW-1:0];
          emit              = 1'b1;
          e_has             = node_has;
          e_blk             = node_has ? node_blk : '0;
          e_end             = (ram_rdata[IW-1:0] == '0);
          state_next        = fcw_pkg::ST_IDLE;
        end
      end

      fcw_pkg::ST_PAIR: begin
        // run end index from the entry after the node
        current_node_next = pair_next;
        emit              = 1'b1;
        e_has             = node_has;
        e_blk             = node_has ? node_blk : '0;
        state_next        = fcw_pkg::ST_IDLE;
        if ({1'b0, ram_rdata[IW-1:0]} >= node_succ) begin
          run_position_next = node_succ[IW-1:0];
          run_last_next     = ram_rdata[IW-1:0];
          phase_next        = fcw_pkg::PH_RUN;
        end else begin
          e_end = (pair_next == '0);
        end
      end

      default: state_next = fcw_pkg::ST_IDLE;
    endcase

    // Load the output register
    if (emit) begin
      result_next.block_number = e_blk;
      result_next.has_block    = e_has;
      result_next.chain_end    = e_end;
      result_next.bad_index    = e_bad;
      result_valid_next        = 1'b1;
      if (e_end || e_bad) begin
        phase_next = fcw_pkg::PH_IDLE;
      end
    end
  end

endmodule

@@ src/fcw_checker.sv @@
`timescale 1ns / 1ps
module fcw_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_ready,
  input fcw_pkg::result_t result
);

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // No result straight out of reset
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Block number is zero when no block is reported
  a_noblk: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_block |-> result.block_number == '0)
    else $error("block number set without a block");

  // A walk ends either cleanly or on error, not both
  a_endbad: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.chain_end && result.bad_index))
    else $error("chain end and bad index together");

  // Block numbers come from nonzero indices
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.has_block |-> result.block_number != '1)
    else $error("block number out of range");

endmodule

bind fat_chain_walker fcw_checker u_fcw_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ verif/fat_chain_walker_tb.sv @@
`timescale 1ns / 1ps
module fat_chain_walker_tb;

  localparam int TblN = fcw_pkg::TableEntriesDefault;
  localparam int IdxW = fcw_pkg::IdxW;
  localparam int EntryW = fcw_pkg::EntryW;
  localparam int StepW = fcw_pkg::StepW;
  localparam int StallLimit = 400;
  localparam int SettleCycles = 8;
  localparam int ItemsPerPhase = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  fcw_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  fcw_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_data = '0;

  // Shadow walker state: view 0 plans the stimulus, view 1 tracks accepted beats
  logic [EntryW-1:0] fat [2][TblN];
  logic [IdxW-1:0] cur_node [2];
  logic [IdxW-1:0] run_pos [2];
  logic [IdxW-1:0] run_end [2];
  fcw_pkg::phase_t walk_ph [2] = '{fcw_pkg::PH_IDLE, fcw_pkg::PH_IDLE};
  logic [StepW-1:0] steps_taken [2];
  logic [IdxW-1:0] used_entries = 12'd4095;

  // Entries written so far; the planner never lets a walk read one that is not
  bit loaded [TblN];

  fcw_pkg::item_t items_todo [$];
  fcw_pkg::result_t blocks_due [$];
  int planned = 0;
  int reg_lo = 0;
  bit no_idle = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int errors = 0;

  fat_chain_walker u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit in_range(input logic [StepW-1:0] i);
    return (i < {1'b0, used_entries}) && (i < TblN);
  endfunction

  // One beat through the walker; returns 1 when the beat yields a result
  function automatic bit walk_item(input bit v, input fcw_pkg::item_t it,
                                   output fcw_pkg::result_t res);
    logic [EntryW-1:0] ent;
    logic [EntryW-1:0] after;
    logic [StepW-1:0] n1;
    logic [IdxW-1:0] n;
    logic [IdxW-1:0] p;
    res = '0;
    if (it.func == fcw_pkg::FN_LOAD) begin
      fat[v][it.entry_index] = {it.entry_flag, it.entry_next};
      return 1'b0;
    end
    if (it.func == fcw_pkg::FN_START) begin
      cur_node[v] = it.start_index;
      run_pos[v] = '0;
      run_end[v] = '0;
      steps_taken[v] = '0;
      walk_ph[v] = fcw_pkg::PH_NODE;
      return 1'b0;
    end
    if (it.func != fcw_pkg::FN_STEP || walk_ph[v] == fcw_pkg::PH_IDLE) return 1'b0;

    if (steps_taken[v] >= {1'b0, used_entries}) begin
      // walk too long
      res.bad_index = 1'b1;
    end else begin
      if (steps_taken[v] != '1) steps_taken[v] = steps_taken[v] + 1'b1;
      if (walk_ph[v] == fcw_pkg::PH_NODE) begin
        n = cur_node[v];
        n1 = {1'b0, n} + 1'b1;
        if (!in_range({1'b0, n})) begin
          res.bad_index = 1'b1;
        end else begin
          ent = fat[v][n];
          res.has_block = (n != '0);
          res.block_number = (n != '0) ? n - 1'b1 : '0;
          if (ent[IdxW] && !in_range(n1)) begin
            // node block still reported, run end unreadable
            res.bad_index = 1'b1;
          end else begin
            cur_node[v] = ent[IdxW-1:0];
            after = ent[IdxW] ? fat[v][n1[IdxW-1:0]] : '0;
            if (ent[IdxW] && {1'b0, after[IdxW-1:0]} >= n1) begin
              run_pos[v] = n1[IdxW-1:0];
              run_end[v] = after[IdxW-1:0];
              walk_ph[v] = fcw_pkg::PH_RUN;
            end else begin
              res.chain_end = (ent[IdxW-1:0] == '0);
            end
          end
        end
      end else begin
        p = run_pos[v];
        if (p == '0 || !in_range({1'b0, p})) begin
          res.bad_index = 1'b1;
        end else begin
          res.has_block = 1'b1;
          res.block_number = p - 1'b1;
          if (p >= run_end[v]) begin
            walk_ph[v] = fcw_pkg::PH_NODE;
            res.chain_end = (cur_node[v] == '0);
          end else begin
            run_pos[v] = p + 1'b1;
          end
        end
      end
    end
    if (res.chain_end || res.bad_index) walk_ph[v] = fcw_pkg::PH_IDLE;
    return 1'b1;
  endfunction

  // Entry the next planned step would read without it ever being loaded, or -1
  function automatic int unloaded_read();
    logic [StepW-1:0] n;
    logic [StepW-1:0] n1;
    if (walk_ph[0] != fcw_pkg::PH_NODE || steps_taken[0] >= {1'b0, used_entries}) return -1;
    n = {1'b0, cur_node[0]};
    n1 = n + 1'b1;
    if (!in_range(n)) return -1;
    if (!loaded[n[IdxW-1:0]]) return int'(n);
    if (fat[0][n[IdxW-1:0]][IdxW] && in_range(n1) && !loaded[n1[IdxW-1:0]])
      return int'(n1);
    return -1;
  endfunction

  function automatic fcw_pkg::item_t mk(input logic [1:0] fn);
    fcw_pkg::item_t it;
    it.func = fn;
    it.entry_index = IdxW'($urandom_range(0, 4095));
    it.entry_next = IdxW'($urandom_range(0, 4095));
    it.entry_flag = 1'($urandom_range(0, 1));
    it.start_index = IdxW'($urandom_range(0, 4095));
    return it;
  endfunction

  function automatic fcw_pkg::item_t load_of(input int idx, input int nxt, input bit flag);
    fcw_pkg::item_t it;
    it = mk(fcw_pkg::FN_LOAD);
    it.entry_index = IdxW'(idx);
    it.entry_next = IdxW'(nxt);
    it.entry_flag = flag;
    return it;
  endfunction

  function automatic fcw_pkg::item_t start_at(input int idx);
    fcw_pkg::item_t it;
    it = mk(fcw_pkg::FN_START);
    it.start_index = IdxW'(idx);
    return it;
  endfunction

  task automatic plan(input fcw_pkg::item_t it);
    fcw_pkg::result_t unused;
    if (it.func == fcw_pkg::FN_LOAD) loaded[it.entry_index] = 1'b1;
    void'(walk_item(1'b0, it, unused));
    items_todo.push_back(it);
    planned++;
  endtask

  // Step beat, preceded by loads of any entry it would otherwise read unwritten
  task automatic plan_step();
    int k;
    int nxt;
    k = unloaded_read();
    while (k >= 0) begin
      nxt = $urandom_range(0, 1) ? 0 : reg_lo + $urandom_range(0, 30);
      if (nxt > 4095) nxt = 4095;
      plan(load_of(k, nxt, $urandom_range(0, 3) == 0));
      k = unloaded_read();
    end
    plan(mk(fcw_pkg::FN_STEP));
  endtask

  // Load a short chain with runs, walk it, and sprinkle in noise beats
  task automatic build_chain();
    int nodes [$];
    int ends [$];
    bit flags [$];
    int ue, pos, len, k, j, e, nxt, cnt, limit;
    bit rev;
    ue = used_entries;
    case ($urandom_range(0, 3))
      0: reg_lo = $urandom_range(1, 4000);
      1: reg_lo = (ue > 20) ? ue - $urandom_range(0, 20) : $urandom_range(0, 4);
      default: reg_lo = $urandom_range(0, (ue > 80) ? ue - 60 : ue);
    endcase
    pos = reg_lo;
    len = $urandom_range(1, 6);
    for (k = 0; k < len && pos <= 4094; k++) begin
      nodes.push_back(pos);
      flags.push_back(pos <= 4093 && $urandom_range(0, 2) == 0);
      if (flags[k]) begin
        if ($urandom_range(0, 5) == 0) begin
          // empty run: end below node+1
          e = pos - $urandom_range(0, 2);
          if (e < 0) e = 0;
        end else begin
          e = pos + 1 + $urandom_range(0, 4);
          if (e > 4095) e = 4095;
        end
        ends.push_back(e);
        pos = ((e > pos + 1) ? e : pos + 1) + 1 + $urandom_range(0, 3);
      end else begin
        ends.push_back(0);
        pos = pos + 1 + $urandom_range(0, 5);
      end
    end

    rev = 1'($urandom_range(0, 1));
    for (k = 0; k < nodes.size(); k++) begin
      j = rev ? nodes.size() - 1 - k : k;
      if (j + 1 < nodes.size()) nxt = nodes[j + 1];
      else if ($urandom_range(0, 4) == 0) nxt = nodes[$urandom_range(0, j)];
      else nxt = 0;
      plan(load_of(nodes[j], nxt, flags[j]));
      if (flags[j]) plan(load_of(nodes[j] + 1, ends[j], 1'($urandom_range(0, 1))));
      case ($urandom_range(0, 15))
        0: plan(mk(fcw_pkg::FN_NONE));
        1: plan_step();
        2: plan(mk(fcw_pkg::FN_LOAD));
        default: ;
      endcase
    end

    plan(start_at(($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : nodes[0]));
    limit = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : 48;
    cnt = 0;
    while (cnt < limit && walk_ph[0] != fcw_pkg::PH_IDLE) begin
      plan_step();
      cnt++;
    end
    if ($urandom_range(0, 5) == 0) plan_step();
  endtask

  // Driver: presents planned beats, random gaps between them
  always @(posedge clk) begin
    fcw_pkg::item_t nxt_item;
    logic nxt_valid;
    fcw_pkg::result_t r;
    bit got;
    nxt_item = item;
    nxt_valid = item_valid;
    if (rst) begin
      nxt_valid = 1'b0;
      gap_left = 0;
    end else begin
      if (item_valid && item_ready) begin
        got = walk_item(1'b1, item, r);
        if (got) blocks_due.push_back(r);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (items_todo.size() > 0) begin
          if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 2);
          end else begin
            nxt_item = items_todo.pop_front();
            nxt_valid = 1'b1;
          end
        end
      end
    end
    item_valid <= nxt_valid;
    item <= nxt_item;
  end

  // Monitor: checks each result beat against the oldest predicted block
  always @(posedge clk) begin
    fcw_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (blocks_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: blk=%0d has=%b end=%b bad=%b",
                   result.block_number, result.has_block, result.chain_end,
                   result.bad_index);
      end else begin
        want = blocks_due.pop_front();
        if (result.block_number !== want.block_number ||
            result.has_block !== want.has_block ||
            result.chain_end !== want.chain_end ||
            result.bad_index !== want.bad_index) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: want blk=%0d has=%b end=%b bad=%b, ",
                      "got blk=%0d has=%b end=%b bad=%b"},
                     want.block_number, want.has_block, want.chain_end, want.bad_index,
                     result.block_number, result.has_block, result.chain_end,
                     result.bad_index);
        end
      end
    end
    // receiver stalls in short bursts
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sequencer: reset, then phases of table sizes with directed and random beats
  initial begin
    int counts [7];
    int p;
    int target;
    counts = '{4095, 1, 7, 2048, 100, 4095, 0};
    counts[6] = $urandom_range(1, 4095);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (p = 0; p < 7; p++) begin
      // let the block drain before touching the register
      do @(negedge clk);
      while (items_todo.size() != 0 || item_valid || blocks_due.size() != 0);
      repeat (SettleCycles) @(negedge clk);
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_data <= IdxW'(counts[p]);
      @(posedge clk);
      cfg_we <= 1'b0;
      @(negedge clk);
      used_entries = IdxW'(counts[p]);
      no_idle = (p == 6);

      if (p == 0) begin
        plan(mk(fcw_pkg::FN_NONE));
        plan_step();                      // step with no walk active
        plan(start_at(4095));             // node out of range
        plan_step();
        plan(load_of(0, 0, 0));           // node zero: no block, chain ends
        plan(start_at(0));
        plan_step();
        plan(load_of(10, 20, 1));         // run 11..12, then empty run at 20
        plan(load_of(11, 12, 0));
        plan(load_of(20, 0, 1));
        plan(load_of(21, 5, 1));
        plan(start_at(10));
        repeat (4) plan_step();
        plan(load_of(4094, 0, 1));        // flagged node, following entry out of range
        plan(start_at(4094));
        plan_step();
        plan(load_of(4090, 0, 1));        // run member runs out of range
        plan(load_of(4091, 4095, 0));
        plan(start_at(4090));
        repeat (6) plan_step();
      end
      if (p == 2) begin
        // two-node loop runs into the step limit
        plan(load_of(2, 3, 0));
        plan(load_of(3, 2, 0));
        plan(start_at(2));
        repeat (8) plan_step();
      end

      target = planned + ItemsPerPhase;
      while (planned < target) build_chain();
    end

    do @(negedge clk);
    while (items_todo.size() != 0 || item_valid || blocks_due.size() != 0);
    repeat (SettleCycles) @(negedge clk);
    if (errors == 0 && blocks_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
